// ===== design/mpc_pkg.sv =====
// Shared types and constants for the manual pairing code generator.
package mpc_pkg;

  // Code lengths, counted in digits
  localparam int unsigned SHORT_LEN = 11;
  localparam int unsigned LONG_LEN  = 21;

  // Validation limits
  localparam logic [31:0] PIN_MAX  = 32'd99999998;
  localparam logic [15:0] DISC_MAX = 16'h0FFF;

  // Reciprocal of ten for 16-bit values: q = (v * DIV10_MUL) >> DIV10_SHIFT
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT = 19;

  // Commissioning flow codes
  localparam logic [1:0] FLOW_STANDARD = 2'd0;
  localparam logic [1:0] FLOW_INVALID  = 2'd3;

  // Verhoeff dihedral group product
  localparam logic [3:0] VH_D [10][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
    '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
    '{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
    '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
    '{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
    '{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
    '{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
    '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
  };

  // Verhoeff position permutation, row picked by position mod 8
  localparam logic [3:0] VH_P [8][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
    '{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
    '{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
    '{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
    '{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
    '{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
    '{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
  };

  // Verhoeff inverse
  localparam logic [3:0] VH_INV [10] = '{
    4'd0, 4'd4, 4'd3, 4'd2, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // Control from the sequencer to the checksum unit
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [3:0] digit;
  } vh_ctl_t;

endpackage

// ===== design/mpc_verhoeff.sv =====
// Verhoeff checksum accumulator, one digit per step, least significant digit first.
module mpc_verhoeff (
  input  logic             clk,
  input  mpc_pkg::vh_ctl_t ctl,
  output logic [3:0]       check_digit
);
  import mpc_pkg::*;

  logic [3:0] sum_r, sum_nxt;
  logic [2:0] ph_r, ph_nxt;

  // Clear for a new code, or fold in one digit at the current position
  always_comb begin
    sum_nxt = sum_r;
    ph_nxt  = ph_r;
    priority if (ctl.clear) begin
      sum_nxt = 4'd0;
      ph_nxt  = 3'd1;
    end else if (ctl.step) begin
      sum_nxt = VH_D[sum_r][VH_P[ph_r][ctl.digit]];
      ph_nxt  = ph_r + 3'd1;
    end else begin
      // Hold the running sum and position
      sum_nxt = sum_r;
      ph_nxt  = ph_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    ph_r  <= ph_nxt;
  end

  assign check_digit = VH_INV[sum_r];

endmodule

// ===== design/manual_pairing_code_generator_core.sv =====
// Manual pairing code generator: one payload in, 11 or 21 code digits (or one reject) out.
// A payload transfer is taken only while the block is idle. A rejected payload gives a
// single result with payload_ok low, loaded into the output register from the reject
// state once the output slot is free. A valid payload runs through one shared
// divide-by-ten unit that peels one decimal digit a cycle while the Verhoeff sum follows,
// a check state writes the check digit, then the digits stream out most significant first
// at one per cycle when out_ready stays high.
// The next payload is taken while the final digit still waits in the output register.
module manual_pairing_code_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_setup_pin,
  input  logic [15:0] in_discriminator_value,
  input  logic [1:0]  in_flow_kind,
  input  logic [15:0] in_vendor_number,
  input  logic [15:0] in_product_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_code_digit,
  output logic        out_is_last,
  output logic        out_payload_ok
);
  import mpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXTRACT = 5'b00010,
    S_CHECK   = 5'b00100,
    S_EMIT    = 5'b01000,
    S_REJECT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    FLD_PROD,
    FLD_VEND,
    FLD_C3,
    FLD_C2,
    FLD_C1
  } fld_t;

  localparam logic [4:0] SHORT_LAST = 5'(SHORT_LEN - 1);
  localparam logic [4:0] LONG_LAST  = 5'(LONG_LEN - 1);

  state_t      state_r, state_nxt;
  fld_t        fld_r;
  logic [15:0] val_r;
  logic [2:0]  dleft_r;
  logic [4:0]  wpos_r;
  logic [4:0]  rpos_r;
  logic [4:0]  last_r;
  logic [2:0]  c1_r;
  logic [15:0] c2_r;
  logic [12:0] c3_r;
  logic [15:0] vend_r;
  logic [3:0]  buf_r [LONG_LEN];
  logic        out_valid_r;
  logic [3:0]  out_digit_r;
  logic        out_last_r;
  logic        out_ok_r;

  logic        accept;
  logic        longc;
  logic        payload_ok;
  logic        out_free;
  logic [31:0] prod_w;
  logic [12:0] quot_w;
  logic [15:0] rem_full;
  logic [3:0]  rem_w;
  logic [3:0]  check_digit;
  vh_ctl_t     vh_ctl;

  // Passcode range and trivial pattern check
  function automatic logic pin_ok(input logic [31:0] pin);
    logic ok;
    ok = (pin != 32'd0) && (pin <= PIN_MAX);
    if ((pin == 32'd11111111) || (pin == 32'd22222222) || (pin == 32'd33333333) ||
        (pin == 32'd44444444) || (pin == 32'd55555555) || (pin == 32'd66666666) ||
        (pin == 32'd77777777) || (pin == 32'd88888888) || (pin == 32'd12345678) ||
        (pin == 32'd87654321)) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign longc    = (in_flow_kind != FLOW_STANDARD);

  assign payload_ok = pin_ok(in_setup_pin) && (in_discriminator_value <= DISC_MAX) &&
                      (in_flow_kind != FLOW_INVALID) &&
                      !((in_vendor_number != 16'd0) && (in_product_number == 16'd0));

  // Shared divide-by-ten unit: quotient by reciprocal, remainder by shift and subtract
  assign prod_w   = {16'd0, val_r} * {16'd0, DIV10_MUL};
  assign quot_w   = prod_w[31:DIV10_SHIFT];
  assign rem_full = val_r - {quot_w, 3'b000} - {2'b00, quot_w, 1'b0};
  assign rem_w    = rem_full[3:0];

  // Drive the checksum unit
  always_comb begin
    vh_ctl       = '0;
    vh_ctl.clear = accept;
    vh_ctl.step  = (state_r == S_EXTRACT);
    vh_ctl.digit = rem_w;
  end

  mpc_verhoeff u_verhoeff (
    .clk         (clk),
    .ctl         (vh_ctl),
    .check_digit (check_digit)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = payload_ok ? S_EXTRACT : S_REJECT;
        end
      end
      S_EXTRACT: begin
        if ((dleft_r == 3'd1) && (fld_r == FLD_C1)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free && (rpos_r == last_r)) begin
          state_nxt = S_IDLE;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == S_EMIT) || (state_r == S_REJECT)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the payload fields and start with the last field, least significant digit
  always_ff @(posedge clk) begin
    if (accept) begin
      c1_r   <= {longc, in_discriminator_value[11:10]};
      c2_r   <= {in_discriminator_value[9:8], in_setup_pin[13:0]};
      c3_r   <= in_setup_pin[26:14];
      vend_r <= in_vendor_number;
      rpos_r <= 5'd0;
      if (longc) begin
        val_r   <= in_product_number;
        fld_r   <= FLD_PROD;
        dleft_r <= 3'd5;
        wpos_r  <= LONG_LAST - 5'd1;
        last_r  <= LONG_LAST;
      end else begin
        val_r   <= {3'b000, in_setup_pin[26:14]};
        fld_r   <= FLD_C3;
        dleft_r <= 3'd4;
        wpos_r  <= SHORT_LAST - 5'd1;
        last_r  <= SHORT_LAST;
      end
    end else if (state_r == S_EXTRACT) begin
      // Store one digit, then advance within the field or move to the next one
      buf_r[wpos_r] <= rem_w;
      wpos_r        <= wpos_r - 5'd1;
      if (dleft_r == 3'd1) begin
        unique case (fld_r)
          FLD_PROD: begin
            fld_r   <= FLD_VEND;
            val_r   <= vend_r;
            dleft_r <= 3'd5;
          end
          FLD_VEND: begin
            fld_r   <= FLD_C3;
            val_r   <= {3'b000, c3_r};
            dleft_r <= 3'd4;
          end
          FLD_C3: begin
            fld_r   <= FLD_C2;
            val_r   <= c2_r;
            dleft_r <= 3'd5;
          end
          FLD_C2: begin
            fld_r   <= FLD_C1;
            val_r   <= {13'd0, c1_r};
            dleft_r <= 3'd1;
          end
          FLD_C1: begin
            fld_r   <= FLD_C1;
            val_r   <= 16'd0;
            dleft_r <= 3'd0;
          end
          default: begin
            fld_r   <= FLD_C1;
            val_r   <= 16'd0;
            dleft_r <= 3'd0;
          end
        endcase
      end else begin
        val_r   <= {3'b000, quot_w};
        dleft_r <= dleft_r - 3'd1;
      end
    end else if (state_r == S_CHECK) begin
      buf_r[last_r] <= check_digit;
    end else if ((state_r == S_EMIT) && out_free) begin
      rpos_r <= rpos_r + 5'd1;
    end
  end

  // Output register: load a digit or the reject result when the slot is free
  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_digit_r <= buf_r[rpos_r];
      out_last_r  <= (rpos_r == last_r);
      out_ok_r    <= 1'b1;
    end else if ((state_r == S_REJECT) && out_free) begin
      out_digit_r <= 4'd0;
      out_last_r  <= 1'b1;
      out_ok_r    <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_digit = out_digit_r;
  assign out_is_last    = out_last_r;
  assign out_payload_ok = out_ok_r;

  // A reject is a single zero result that closes the payload
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_ok) |-> (out_is_last && (out_code_digit == 4'd0)))
    else $error("reject result not a single zero digit");

  // Every emitted digit is decimal
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_ok) |-> (out_code_digit <= 4'd9))
    else $error("code digit out of decimal range");

  // No second payload is taken right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after payload transfer");

  // Extraction ends with the write pointer just below the first digit
  a_extract_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHECK)) |-> (wpos_r == 5'h1F))
    else $error("digit count mismatch at check digit");

endmodule

// ===== sim/manual_pairing_code_generator_core_tb.sv =====
// Testbench for the manual pairing code generator: random and directed payloads, checked digit by digit.
`timescale 1ns / 1ps

module manual_pairing_code_generator_core_tb;
  import mpc_pkg::*;

  // Flow codes the package leaves out
  localparam logic [1:0] FLOW_USER_ACTION = 2'd1;
  localparam logic [1:0] FLOW_CUSTOM      = 2'd2;

  // Trivial passcodes: repdigits are multiples of this unit, plus two runs
  localparam int unsigned REPDIGIT_UNIT  = 11111111;
  localparam int unsigned ASCENDING_PIN  = 12345678;
  localparam int unsigned DESCENDING_PIN = 87654321;

  localparam int unsigned RANDOM_PAYLOADS = 210;
  localparam int unsigned DRAIN_CYCLES    = 60;

  typedef struct packed {
    logic [31:0] pin;
    logic [15:0] disc;
    logic [1:0]  flow;
    logic [15:0] vendor;
    logic [15:0] product;
  } payload_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
    logic       ok;
  } code_digit_t;

  // Predicts the digit stream of each payload and matches it against the output
  class pairing_code_board;
    code_digit_t expected_digits[$];
    int unsigned code_buf[$];
    int unsigned perm_one[10];
    int unsigned mismatches;

    function new();
      perm_one   = '{1, 5, 7, 6, 2, 8, 3, 0, 9, 4};
      mismatches = 0;
    endfunction

    // Product in the dihedral group of order ten
    function int unsigned dihedral_mul(int unsigned j, int unsigned k);
      if (j < 5 && k < 5) return (j + k) % 5;
      if (j < 5) return 5 + (j + k) % 5;
      if (k < 5) return 5 + (j - k + 5) % 5;
      return (j + 5 - k) % 5;
    endfunction

    // Position permutation, applied (position mod 8) times
    function int unsigned permute(int unsigned position, int unsigned digit);
      int unsigned v;
      v = digit;
      for (int unsigned n = 0; n < (position % 8); n++) v = perm_one[v];
      return v;
    endfunction

    function int unsigned group_inverse(int unsigned j);
      return (j < 5) ? (5 - j) % 5 : j;
    endfunction

    // Append a zero-padded decimal field, most significant digit first
    function void append_decimal(int unsigned value, int unsigned count);
      int unsigned tmp[5];
      int unsigned v;
      v = value;
      for (int k = int'(count) - 1; k >= 0; k--) begin
        tmp[k] = v % 10;
        v = v / 10;
      end
      for (int unsigned k = 0; k < count; k++) code_buf.push_back(tmp[k]);
    endfunction

    function bit pin_acceptable(logic [31:0] pin);
      if (pin == 0 || pin > PIN_MAX) return 1'b0;
      if (pin % REPDIGIT_UNIT == 0) return 1'b0;
      if (pin == ASCENDING_PIN || pin == DESCENDING_PIN) return 1'b0;
      return 1'b1;
    endfunction

    // Note an accepted payload and queue the digits it should produce
    function void note_payload(payload_t p);
      bit          long_code;
      int unsigned acc;
      int unsigned len;
      code_digit_t r;
      if (!pin_acceptable(p.pin) || p.disc > DISC_MAX || p.flow == FLOW_INVALID ||
          (p.vendor != 0 && p.product == 0)) begin
        r.digit = 4'd0;
        r.last  = 1'b1;
        r.ok    = 1'b0;
        expected_digits.push_back(r);
        return;
      end
      long_code = (p.flow != FLOW_STANDARD);
      code_buf.delete();
      append_decimal(int'(p.disc[11:10]) + (long_code ? 4 : 0), 1);
      append_decimal({p.disc[9:8], p.pin[13:0]}, 5);
      append_decimal(p.pin[26:14], 4);
      if (long_code) begin
        append_decimal(p.vendor, 5);
        append_decimal(p.product, 5);
      end
      // Fold the Verhoeff sum from the least significant digit up
      acc = 0;
      len = code_buf.size();
      for (int unsigned i = 0; i < len; i++)
        acc = dihedral_mul(acc, permute(i + 1, code_buf[len - 1 - i]));
      code_buf.push_back(group_inverse(acc));
      len = code_buf.size();
      for (int unsigned i = 0; i < len; i++) begin
        r.digit = 4'(code_buf[i]);
        r.last  = (i + 1 == len);
        r.ok    = 1'b1;
        expected_digits.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Check one result transfer against the oldest expected digit
    task check_digit(logic [3:0] digit, logic last, logic ok);
      code_digit_t e;
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected result digit=%0d last=%0b ok=%0b",
                                  digit, last, ok));
        return;
      end
      e = expected_digits.pop_front();
      if (ok !== e.ok)
        report_mismatch($sformatf("payload_ok got %0b want %0b", ok, e.ok));
      if (last !== e.last)
        report_mismatch($sformatf("is_last got %0b want %0b", last, e.last));
      if (digit !== e.digit)
        report_mismatch($sformatf("code_digit got %0d want %0d", digit, e.digit));
    endtask

    function int unsigned pending();
      return expected_digits.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_setup_pin = '0;
  logic [15:0] in_discriminator_value = '0;
  logic [1:0]  in_flow_kind = FLOW_STANDARD;
  logic [15:0] in_vendor_number = '0;
  logic [15:0] in_product_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_code_digit;
  logic        out_is_last;
  logic        out_payload_ok;

  pairing_code_board board = new();
  int unsigned       burst_left = 0;

  manual_pairing_code_generator_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_setup_pin           (in_setup_pin),
    .in_discriminator_value (in_discriminator_value),
    .in_flow_kind           (in_flow_kind),
    .in_vendor_number       (in_vendor_number),
    .in_product_number      (in_product_number),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_code_digit         (out_code_digit),
    .out_is_last            (out_is_last),
    .out_payload_ok         (out_payload_ok)
  );

  always #6 clk = ~clk;

  // Offer one payload and hold it until the transfer; idle for a random gap, possibly none, between bursts
  task send_payload(payload_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid               <= 1'b1;
    in_setup_pin           <= p.pin;
    in_discriminator_value <= p.disc;
    in_flow_kind           <= p.flow;
    in_vendor_number       <= p.vendor;
    in_product_number      <= p.product;
    do @(posedge clk); while (!in_ready);
    board.note_payload(p);
  endtask

  task send_fields(logic [31:0] pin, logic [15:0] disc, logic [1:0] flow,
                   logic [15:0] vendor, logic [15:0] product);
    payload_t p;
    p.pin     = pin;
    p.disc    = disc;
    p.flow    = flow;
    p.vendor  = vendor;
    p.product = product;
    send_payload(p);
  endtask

  // Mostly well-formed payloads with random content, the rest raw noise
  task send_random_payload();
    payload_t    p;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      p.pin     = $urandom_range(1, PIN_MAX);
      p.disc    = 16'($urandom_range(0, DISC_MAX));
      p.flow    = 2'($urandom_range(0, 2));
      p.vendor  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      p.product = (p.vendor == 0 && $urandom_range(0, 1) == 0) ? 16'd0 :
                  16'($urandom_range(1, 65535));
    end else begin
      p.pin     = (roll < 92) ? $urandom : $urandom_range(1, PIN_MAX);
      p.disc    = (roll % 2 == 0) ? 16'($urandom) : 16'($urandom_range(0, DISC_MAX));
      p.flow    = 2'($urandom);
      p.vendor  = 16'($urandom);
      p.product = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    end
    send_payload(p);
  endtask

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_digit(out_code_digit, out_is_last, out_payload_ok);
  end

  // Receiver: segments of steady, random and periodic ready, with long hold-offs
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned span;
    seg = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      if (seg % 30 == 3) begin
        // Hold off long enough for the block to fill and stall its input
        out_ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else begin
        for (int unsigned c = 0; c < span; c++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 99) < 60);
            default: out_ready <= (c % 5 < 3);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest and largest valid codes, and passcodes next to a repdigit
    send_fields(32'd1, 16'd0, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(PIN_MAX, DISC_MAX, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(PIN_MAX, DISC_MAX, FLOW_USER_ACTION, 16'hFFFF, 16'hFFFF);
    send_fields(32'd11111110, 16'h0A5A, FLOW_CUSTOM, 16'd0, 16'd0);
    send_fields(32'd11111112, 16'h0500, FLOW_USER_ACTION, 16'd0, 16'd12345);
    // Out-of-range passcodes
    send_fields(32'd0, 16'd0, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(PIN_MAX + 32'd1, 16'd0, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(32'hFFFF_FFFF, 16'd0, FLOW_STANDARD, 16'd0, 16'd0);
    // Trivial passcodes
    for (int unsigned k = 1; k <= 8; k++)
      send_fields(REPDIGIT_UNIT * k, 16'd100, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(ASCENDING_PIN, 16'd100, FLOW_CUSTOM, 16'd1, 16'd1);
    send_fields(DESCENDING_PIN, 16'd100, FLOW_USER_ACTION, 16'd1, 16'd1);
    // Discriminator out of range, invalid flow, vendor without product
    send_fields(32'd20202021, DISC_MAX + 16'd1, FLOW_STANDARD, 16'd0, 16'd0);
    send_fields(32'd20202021, 16'hFFFF, FLOW_CUSTOM, 16'd5, 16'd5);
    send_fields(32'd20202021, 16'd3840, FLOW_INVALID, 16'd0, 16'd0);
    send_fields(32'd20202021, 16'd3840, FLOW_CUSTOM, 16'hFFF1, 16'd0);
    send_fields(32'd20202021, 16'd3840, FLOW_STANDARD, 16'd1, 16'd0);

    repeat (RANDOM_PAYLOADS) send_random_payload();
    in_valid <= 1'b0;

    // Drain outstanding digits, then give stray results a chance to show
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mpc_pkg.sv
design/mpc_verhoeff.sv
design/manual_pairing_code_generator_core.sv
sim/manual_pairing_code_generator_core_tb.sv
